// ===== hdl/asw_pkg.sv =====
// Shared types and constants for the ancestor species walk block.
package asw_pkg;

	// Field widths of the streamed items and the configuration register.
	localparam int INDEX_W   = 9;
	localparam int SPECIES_W = 32;
	localparam int TARGET_W  = 31;
	localparam int ENTRY_W   = SPECIES_W + INDEX_W;

	// Packed stream widths, padded to whole bytes.
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 8;

	localparam logic [TARGET_W-1:0] TARGET_RESET = 31'd24;

	// Item kinds carried on the input tuser.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Fault codes of a result.
	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_LINK  = 2'd1;
	localparam logic [1:0] FAULT_STEPS = 2'd2;

	// Walk sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_WALK
	} walk_state_t;

endpackage

// ===== hdl/asw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module asw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, with registered read data.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/ancestor_species_walk_core.sv =====
// Ancestor species walk: particle table with parent-link search for a target species.
//
//   Channel  Signals                                  Moves
//   s        s_tvalid s_tready s_tdata s_tuser        load or query item
//   m        m_tvalid m_tready m_tdata                query result item
//   cfg      cfg_we cfg_data                          target species register
//
// A load is written to the table in its accept cycle. A query reads its start entry
// and then follows parent links, one entry per cycle from the single read port of
// the table RAM; a negative or out-of-table start reads nothing, and its result is
// registered from the accept cycle. Reset clears the sequencer, the output valid
// and the target register (to 24); the table holds no reset. The input is not
// ready while a walk runs or while a result waits for m_tready.
module ancestor_species_walk_core #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// s_tdata: entry_index[8:0], species_code[40:9], parent_index[49:41], zero pad
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [asw_pkg::S_DATA_W-1:0] s_tdata,
	// s_tuser: kind[0]
	input  logic                         s_tuser,
	// m_tdata: found[0], fault[2:1], zero pad
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [asw_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                         cfg_we,
	input  logic [asw_pkg::TARGET_W-1:0] cfg_data
);
	import asw_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	walk_state_t state_q, state_d;

	logic [TARGET_W-1:0]  target_q;
	logic [SPECIES_W-1:0] start_q;
	logic [AW-1:0]        steps_q;
	logic                 m_tvalid_q;
	logic                 found_q;
	logic [1:0]           fault_q;

	logic [INDEX_W-1:0]   in_index;
	logic [SPECIES_W-1:0] in_species;
	logic [INDEX_W-1:0]   in_parent;
	logic                 in_acc;
	logic                 in_range;

	logic                 ram_we;
	logic [AW-1:0]        ram_raddr;
	logic [ENTRY_W-1:0]   ram_rdata;
	logic [SPECIES_W-1:0] rd_species;
	logic [INDEX_W-1:0]   rd_parent;
	logic [SPECIES_W-1:0] rd_mag;
	logic                 link_ok;

	logic                 res_go;
	logic                 res_found;
	logic [1:0]           res_fault;
	logic                 start_ld;
	logic                 step_clr;
	logic                 step_inc;

	// Unpack the input item.
	assign in_index   = s_tdata[INDEX_W-1:0];
	assign in_species = s_tdata[INDEX_W+SPECIES_W-1:INDEX_W];
	assign in_parent  = s_tdata[ENTRY_W+INDEX_W-1:ENTRY_W];
	assign in_range   = 32'(in_index[INDEX_W-2:0]) < TABLE_DEPTH;

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign in_acc   = s_tvalid && s_tready;

	// Table RAM: species in the low bits, parent link above.
	assign ram_we = in_acc && (s_tuser == KIND_LOAD) && !in_index[INDEX_W-1] && in_range;

	asw_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(in_index[INDEX_W-2:0])),
		.wdata({in_parent, in_species}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Fields of the entry read in the previous cycle.
	assign rd_species = ram_rdata[SPECIES_W-1:0];
	assign rd_parent  = ram_rdata[ENTRY_W-1:SPECIES_W];
	assign rd_mag     = rd_species[SPECIES_W-1] ? (~rd_species + 32'd1) : rd_species;
	assign link_ok    = !rd_parent[INDEX_W-1] && (32'(rd_parent[INDEX_W-2:0]) < TABLE_DEPTH);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, read address and result of the walk.
	always_comb begin
		state_d   = state_q;
		ram_raddr = '0;
		res_go    = 1'b0;
		res_found = 1'b0;
		res_fault = FAULT_NONE;
		start_ld  = 1'b0;
		step_clr  = 1'b0;
		step_inc  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && (s_tuser == KIND_QUERY)) begin
					if (in_index[INDEX_W-1]) begin
						res_go = 1'b1;
					end else if (!in_range) begin
						res_go    = 1'b1;
						res_fault = FAULT_LINK;
					end else begin
						ram_raddr = AW'(in_index[INDEX_W-2:0]);
						state_d   = S_START;
					end
				end
			end
			S_START: begin
				// The start entry fixes the species to follow.
				start_ld = 1'b1;
				step_clr = 1'b1;
				if (!link_ok) begin
					res_go    = 1'b1;
					res_fault = FAULT_LINK;
					state_d   = S_IDLE;
				end else begin
					ram_raddr = AW'(rd_parent[INDEX_W-2:0]);
					state_d   = S_WALK;
				end
			end
			S_WALK: begin
				priority if (rd_mag == {1'b0, target_q}) begin
					res_go    = 1'b1;
					res_found = 1'b1;
					state_d   = S_IDLE;
				end else if (rd_species != start_q) begin
					res_go  = 1'b1;
					state_d = S_IDLE;
				end else if (steps_q == AW'(TABLE_DEPTH - 1)) begin
					res_go    = 1'b1;
					res_fault = FAULT_STEPS;
					state_d   = S_IDLE;
				end else if (!link_ok) begin
					res_go    = 1'b1;
					res_fault = FAULT_LINK;
					state_d   = S_IDLE;
				end else begin
					ram_raddr = AW'(rd_parent[INDEX_W-2:0]);
					step_inc  = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Walk data: start species and link count.
	always_ff @(posedge clk) begin
		if (start_ld) begin
			start_q <= rd_species;
		end
		if (step_clr) begin
			steps_q <= '0;
		end else if (step_inc) begin
			steps_q <= steps_q + AW'(1);
		end
	end

	// Target species register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg_we) begin
			target_q <= cfg_data;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (res_go) begin
			found_q <= res_found;
			fault_q <= res_fault;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, fault_q, found_q};

endmodule

// ===== hdl/asw_checker.sv =====
// Port-level checks for the ancestor species walk, bound to its top level.
module asw_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [asw_pkg::S_DATA_W-1:0] s_tdata,
	input logic                         s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [asw_pkg::M_DATA_W-1:0] m_tdata
);
	import asw_pkg::*;

	// A found result never carries a fault, and no undefined fault code appears.
	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[0] || (m_tdata[2:1] == FAULT_NONE))
			&& (m_tdata[2:1] != 2'd3) && (m_tdata[7:3] == 5'd0))
		else $error("bad result encoding");

	// Input is blocked while a result is stalled.
	a_block_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input ready while result stalled");

	// A query with a negative start answers not found without fault next cycle.
	a_neg_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == KIND_QUERY) && s_tdata[8])
			|=> (m_tvalid && (m_tdata[2:0] == 3'd0)))
		else $error("negative start not answered");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind ancestor_species_walk_core asw_checker u_asw_checker (.*);
